### hdl/imm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Interval mean, min and max package
// Shared request codes, reset and width constants and the controller/datapath bundles.
// ---------------------------------------------------------------------------
package imm_pkg;

   localparam logic       OP_ACCUMULATE = 1'b0;
   localparam logic       OP_READ       = 1'b1;

   localparam logic [30:0] DEFAULT_BOUND = 31'd16777216;

   localparam int CURRENT_BITS = 32;
   localparam int VOLTAGE_BITS = 24;

   typedef struct packed {
      logic accumulate;
      logic snapshot;
      logic step;
      logic load_result;
   } cmd_type;

   typedef struct packed {
      logic div_last;
   } status_type;

endpackage

`default_nettype wire

### hdl/interval_mean_min_max.sv
// Accumulate requests are accepted every cycle, also while a read is being divided.
// A read request snapshots and clears the interval at once; its result is computed
// by a restoring divider that retires one quotient bit per cycle. A further read is
// held off until that result has moved into the output register. Reset is synchronous:
// the bound returns to one ampere and the interval is cleared in the same cycle.
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Interval mean, min and max accumulator
// Sums paired current and voltage samples, tracks current extremes, and
// reports means, extremes and count on a read-and-clear request.
// ---------------------------------------------------------------------------
module interval_mean_min_max #(
   parameter int COUNT_BITS = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // Bits from the lowest: current_sample[31:0], voltage_sample[55:32].
   input  wire logic [55:0]  req_tdata,
   // Bits from the lowest: operation[0].
   input  wire logic [0:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // Bits from the lowest: mean_current[31:0], mean_voltage[55:32],
   // lowest_current[87:56], highest_current[119:88], interval_samples[151:120].
   output logic [151:0]      rsp_tdata,
   input  wire logic         csr_wr_en,
   input  wire logic [30:0]  csr_wr_data
);

   imm_pkg::cmd_type    cmd;
   imm_pkg::status_type status;
   logic signed [31:0]  mean_current;
   logic signed [23:0]  mean_voltage;
   logic signed [31:0]  lowest_current;
   logic signed [31:0]  highest_current;
   logic [31:0]         interval_samples;

   imm_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_operation (req_tuser[0]),
      .req_tready    (req_tready),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .cmd           (cmd),
      .status        (status)
   );

   imm_datapath #(
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_current      (signed'(req_tdata[31:0])),
      .req_voltage      (signed'(req_tdata[55:32])),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .mean_current     (mean_current),
      .mean_voltage     (mean_voltage),
      .lowest_current   (lowest_current),
      .highest_current  (highest_current),
      .interval_samples (interval_samples)
   );

   assign rsp_tdata = {interval_samples, highest_current, lowest_current,
                       mean_voltage, mean_current};

endmodule

`default_nettype wire

### hdl/imm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Interval mean, min and max controller
// Sequences snapshot, division and result hand-off; owns the result valid.
// ---------------------------------------------------------------------------
module imm_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   input  wire logic               req_operation,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output imm_pkg::cmd_type        cmd,
   input  wire imm_pkg::status_type status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_HOLD
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      accept;

   assign req_tready = (req_operation == imm_pkg::OP_ACCUMULATE) || (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in        = state_ff;
      rsp_valid_in    = rsp_valid_ff;
      cmd             = '0;
      cmd.accumulate  = accept && (req_operation == imm_pkg::OP_ACCUMULATE);
      cmd.snapshot    = accept && (req_operation == imm_pkg::OP_READ);
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.snapshot) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
            if (status.div_last) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_result = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   a_no_read_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !cmd.snapshot)
      else $error("read request accepted while the divider is busy");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_result |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over an unclaimed result");

   a_last_step_to_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && status.div_last) |=> (state_ff == ST_HOLD))
      else $error("division end not followed by result hold");
`endif

endmodule

`default_nettype wire

### hdl/imm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Interval mean, min and max datapath
// Accumulators, bound register, shared-step restoring divider, result register.
// ---------------------------------------------------------------------------
module imm_datapath #(
   parameter int COUNT_BITS = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire imm_pkg::cmd_type    cmd,
   output imm_pkg::status_type      status,
   input  wire logic signed [31:0]  req_current,
   input  wire logic signed [23:0]  req_voltage,
   input  wire logic                csr_wr_en,
   input  wire logic [30:0]         csr_wr_data,
   output logic signed [31:0]       mean_current,
   output logic signed [23:0]       mean_voltage,
   output logic signed [31:0]       lowest_current,
   output logic signed [31:0]       highest_current,
   output logic [31:0]              interval_samples
);

   localparam int TALLY_BITS = (COUNT_BITS < 32) ? COUNT_BITS : 32;
   localparam int CUR_W      = imm_pkg::CURRENT_BITS + TALLY_BITS;
   localparam int VOL_W      = imm_pkg::VOLTAGE_BITS + TALLY_BITS;
   localparam int STEP_W     = $clog2(CUR_W);
   localparam logic [TALLY_BITS-1:0] TALLY_LIMIT = {TALLY_BITS{1'b1}};
   localparam logic [STEP_W-1:0]     STEP_LAST   = STEP_W'(CUR_W - 1);

   logic [30:0]                  bound_ff;
   logic [TALLY_BITS-1:0]        tally_ff;
   logic signed [CUR_W-1:0]      cur_sum_ff;
   logic signed [VOL_W-1:0]      vol_sum_ff;
   logic signed [31:0]           low_ff;
   logic signed [31:0]           high_ff;

   logic [TALLY_BITS-1:0]        divisor_ff;
   logic                         empty_ff;
   logic                         cur_neg_ff;
   logic                         vol_neg_ff;
   logic [CUR_W-1:0]             cur_q_ff;
   logic [CUR_W-1:0]             vol_q_ff;
   logic [TALLY_BITS-1:0]        cur_r_ff;
   logic [TALLY_BITS-1:0]        vol_r_ff;
   logic signed [31:0]           snap_low_ff;
   logic signed [31:0]           snap_high_ff;
   logic [STEP_W-1:0]            step_ff;

   logic [CUR_W-1:0]             cur_mag;
   logic [VOL_W-1:0]             vol_mag;
   logic [TALLY_BITS:0]          cur_trial;
   logic [TALLY_BITS:0]          vol_trial;
   logic [TALLY_BITS:0]          cur_diff;
   logic [TALLY_BITS:0]          vol_diff;
   logic                         cur_ge;
   logic                         vol_ge;
   logic [31:0]                  cur_quot;
   logic [23:0]                  vol_quot;

   always_comb begin
      cur_mag   = cur_sum_ff[CUR_W-1] ? CUR_W'(-cur_sum_ff) : CUR_W'(cur_sum_ff);
      vol_mag   = vol_sum_ff[VOL_W-1] ? VOL_W'(-vol_sum_ff) : VOL_W'(vol_sum_ff);
      cur_trial = {cur_r_ff, cur_q_ff[CUR_W-1]};
      vol_trial = {vol_r_ff, vol_q_ff[CUR_W-1]};
      cur_ge    = cur_trial >= {1'b0, divisor_ff};
      vol_ge    = vol_trial >= {1'b0, divisor_ff};
      cur_diff  = cur_trial - {1'b0, divisor_ff};
      vol_diff  = vol_trial - {1'b0, divisor_ff};
      cur_quot  = cur_neg_ff ? (~cur_q_ff[31:0] + 32'd1) : cur_q_ff[31:0];
      vol_quot  = vol_neg_ff ? (~vol_q_ff[23:0] + 24'd1) : vol_q_ff[23:0];
   end

   assign status.div_last = (step_ff == STEP_LAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         bound_ff   <= imm_pkg::DEFAULT_BOUND;
         tally_ff   <= '0;
         cur_sum_ff <= '0;
         vol_sum_ff <= '0;
         low_ff     <= signed'(32'(imm_pkg::DEFAULT_BOUND));
         high_ff    <= -signed'(32'(imm_pkg::DEFAULT_BOUND));
      end else begin
         if (csr_wr_en) begin
            bound_ff <= csr_wr_data;
         end
         if (cmd.snapshot) begin
            tally_ff   <= '0;
            cur_sum_ff <= '0;
            vol_sum_ff <= '0;
            low_ff     <= signed'(32'(bound_ff));
            high_ff    <= -signed'(32'(bound_ff));
         end else if (cmd.accumulate && (tally_ff != TALLY_LIMIT)) begin
            tally_ff   <= tally_ff + TALLY_BITS'(1);
            cur_sum_ff <= cur_sum_ff + CUR_W'(req_current);
            vol_sum_ff <= vol_sum_ff + VOL_W'(req_voltage);
            if (req_current < low_ff) begin
               low_ff <= req_current;
            end
            if (req_current > high_ff) begin
               high_ff <= req_current;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.snapshot) begin
         divisor_ff   <= tally_ff;
         empty_ff     <= (tally_ff == '0);
         cur_neg_ff   <= cur_sum_ff[CUR_W-1];
         vol_neg_ff   <= vol_sum_ff[VOL_W-1];
         cur_q_ff     <= cur_mag;
         vol_q_ff     <= CUR_W'(vol_mag);
         cur_r_ff     <= '0;
         vol_r_ff     <= '0;
         snap_low_ff  <= low_ff;
         snap_high_ff <= high_ff;
         step_ff      <= '0;
      end else if (cmd.step) begin
         cur_q_ff <= {cur_q_ff[CUR_W-2:0], cur_ge};
         vol_q_ff <= {vol_q_ff[CUR_W-2:0], vol_ge};
         cur_r_ff <= cur_ge ? cur_diff[TALLY_BITS-1:0] : cur_trial[TALLY_BITS-1:0];
         vol_r_ff <= vol_ge ? vol_diff[TALLY_BITS-1:0] : vol_trial[TALLY_BITS-1:0];
         step_ff  <= step_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         if (empty_ff) begin
            mean_current     <= '0;
            mean_voltage     <= 24'sd1;
            lowest_current   <= '0;
            highest_current  <= '0;
            interval_samples <= '0;
         end else begin
            mean_current     <= signed'(cur_quot);
            mean_voltage     <= signed'(vol_quot);
            lowest_current   <= snap_low_ff;
            highest_current  <= snap_high_ff;
            interval_samples <= 32'(divisor_ff);
         end
      end
   end

`ifndef SYNTH
   a_min_below_max: assert property (@(posedge clock) disable iff (reset)
      (tally_ff != '0) |-> (low_ff <= high_ff))
      else $error("running minimum above running maximum in a non-empty interval");

   a_tally_monotonic: assert property (@(posedge clock) disable iff (reset)
      !cmd.snapshot |=> (tally_ff >= $past(tally_ff)))
      else $error("sample count fell without a read");
`endif

endmodule

`default_nettype wire

### tb/interval_mean_min_max_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Interval mean, min and max accumulator testbench
// Sends accumulate and read-and-clear requests with random pacing, predicts
// each read report from a behavioral model of the interval state, and checks
// every report field by field. Covers empty intervals, field extremes, the
// start bound register and a long output stall.
// ---------------------------------------------------------------------------
module interval_mean_min_max_tb;

   localparam int TALLY_BITS      = 32;
   localparam int READ_LATENCY    = ((TALLY_BITS < 32) ? TALLY_BITS : 32) + 33;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int RANDOM_ITEMS    = 750;
   localparam logic [31:0] TALLY_LIMIT =
      (TALLY_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << TALLY_BITS) - 64'd1);
   localparam logic [30:0] BOUND_TOP = 31'h7FFF_FFFF;

   typedef struct {
      logic signed [31:0] mean_current;
      logic signed [23:0] mean_voltage;
      logic signed [31:0] lowest_current;
      logic signed [31:0] highest_current;
      logic [31:0]        interval_samples;
   } interval_report_type;

   logic          clock       = 1'b0;
   logic          reset       = 1'b1;
   logic          req_tvalid  = 1'b0;
   logic          req_tready;
   logic [55:0]   req_tdata   = '0;
   logic [0:0]    req_tuser   = imm_pkg::OP_ACCUMULATE;
   logic          rsp_tvalid;
   logic          rsp_tready  = 1'b0;
   logic [151:0]  rsp_tdata;
   logic          csr_wr_en   = 1'b0;
   logic [30:0]   csr_wr_data = '0;

   // Interval state as the block should hold it.
   logic [30:0]        start_bound;
   logic [31:0]        tally;
   longint             sum_current;
   longint             sum_voltage;
   logic signed [31:0] low_seen;
   logic signed [31:0] high_seen;

   interval_report_type expected_reports[$];
   int unsigned      mismatch_count   = 0;
   int unsigned      idle_cycles      = 0;
   bit               request_gaps_on  = 1'b1;
   bit               drain_gaps_on    = 1'b1;
   bit               hold_off_pending = 1'b0;

   interval_mean_min_max #(
      .COUNT_BITS(TALLY_BITS)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic logic [31:0] rand_current();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'($urandom_range(0, 64)) - 32'd32;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [23:0] rand_voltage();
      case ($urandom_range(0, 9))
         0: return 24'h7F_FFFF;
         1: return 24'h80_0000;
         2: return 24'($urandom_range(0, 64)) - 24'd32;
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic clear_interval_model();
      tally       = '0;
      sum_current = 0;
      sum_voltage = 0;
      low_seen    = $signed({1'b0, start_bound});
      high_seen   = -$signed({1'b0, start_bound});
   endtask

   task automatic predict_request(input logic op, input logic signed [31:0] cur,
                                  input logic signed [23:0] vol);
      interval_report_type rep;
      if (op == imm_pkg::OP_ACCUMULATE) begin
         if (tally < TALLY_LIMIT) begin
            tally++;
            sum_current += cur;
            sum_voltage += vol;
            if (cur < low_seen) low_seen = cur;
            if (cur > high_seen) high_seen = cur;
         end
      end else begin
         if (tally == 0) begin
            rep.mean_current     = 0;
            rep.mean_voltage     = 1;
            rep.lowest_current   = 0;
            rep.highest_current  = 0;
            rep.interval_samples = 0;
         end else begin
            rep.mean_current     = 32'(sum_current / longint'(tally));
            rep.mean_voltage     = 24'(sum_voltage / longint'(tally));
            rep.lowest_current   = low_seen;
            rep.highest_current  = high_seen;
            rep.interval_samples = tally;
         end
         expected_reports.push_back(rep);
         clear_interval_model();
      end
   endtask

   task automatic send_request(input logic op, input logic [31:0] cur,
                               input logic [23:0] vol);
      int unsigned gap;
      gap = request_gaps_on ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {vol, cur};
      do @(posedge clock); while (req_tready !== 1'b1);
      predict_request(op, cur, vol);
   endtask

   task automatic wait_for_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (READ_LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_bound(input logic [30:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      start_bound = value;
   endtask

   task automatic test_empty_interval();
      send_request(imm_pkg::OP_READ, 32'h0, 24'h0);
      send_request(imm_pkg::OP_READ, 32'hFFFF_FFFF, 24'hFF_FFFF);
   endtask

   task automatic test_field_extremes();
      send_request(imm_pkg::OP_ACCUMULATE, 32'h7FFF_FFFF, 24'h7F_FFFF);
      send_request(imm_pkg::OP_ACCUMULATE, 32'h8000_0000, 24'h80_0000);
      send_request(imm_pkg::OP_READ, 32'h0, 24'h0);
      send_request(imm_pkg::OP_ACCUMULATE, -32'sd3, -24'sd3);
      send_request(imm_pkg::OP_ACCUMULATE, 32'h0, 24'h0);
      send_request(imm_pkg::OP_READ, 32'h0, 24'h0);
      send_request(imm_pkg::OP_ACCUMULATE, 32'h0000_0005, 24'h00_0007);
      send_request(imm_pkg::OP_READ, 32'h0, 24'h0);
   endtask

   task automatic test_bound_outside_samples();
      send_request(imm_pkg::OP_ACCUMULATE, 32'h0200_0000, 24'd100);
      send_request(imm_pkg::OP_ACCUMULATE, 32'h0300_0000, 24'd200);
      send_request(imm_pkg::OP_READ, 32'h0, 24'h0);
      send_request(imm_pkg::OP_ACCUMULATE, -32'sh0200_0000, -24'sd100);
      send_request(imm_pkg::OP_ACCUMULATE, -32'sh0400_0000, 24'd5);
      send_request(imm_pkg::OP_READ, 32'h0, 24'h0);
   endtask

   task automatic test_bound_register();
      wait_for_idle();
      write_bound('0);
      send_request(imm_pkg::OP_READ, 32'h0, 24'h0);
      send_request(imm_pkg::OP_ACCUMULATE, 32'd5, 24'd1);
      send_request(imm_pkg::OP_ACCUMULATE, 32'd7, 24'd2);
      // The new bound must not disturb the interval that is already running.
      wait_for_idle();
      write_bound(BOUND_TOP);
      send_request(imm_pkg::OP_ACCUMULATE, -32'sd4, 24'd3);
      send_request(imm_pkg::OP_READ, 32'h0, 24'h0);
      send_request(imm_pkg::OP_ACCUMULATE, 32'h8000_0000, 24'h80_0000);
      send_request(imm_pkg::OP_READ, 32'h0, 24'h0);
      send_request(imm_pkg::OP_ACCUMULATE, 32'd1, 24'd1);
      send_request(imm_pkg::OP_READ, 32'h0, 24'h0);
   endtask

   task automatic test_output_backpressure();
      wait_for_idle();
      request_gaps_on  = 1'b0;
      hold_off_pending = 1'b1;
      repeat (5) begin
         repeat (3) send_request(imm_pkg::OP_ACCUMULATE, rand_current(), rand_voltage());
         send_request(imm_pkg::OP_READ, $urandom, 24'($urandom));
      end
      request_gaps_on = 1'b1;
   endtask

   task automatic test_random_intervals();
      int unsigned sent;
      int unsigned burst;
      logic [30:0] bound;
      sent = 0;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: bound = '0;
            1: bound = BOUND_TOP;
            2: bound = imm_pkg::DEFAULT_BOUND;
            3: bound = 31'($urandom);
            default: bound = 31'($urandom_range(0, 1 << 20));
         endcase
         wait_for_idle();
         write_bound(bound);
         while (sent < (phase + 1) * (RANDOM_ITEMS / 5)) begin
            burst = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 20);
            request_gaps_on = ($urandom_range(0, 3) != 0);
            drain_gaps_on   = ($urandom_range(0, 3) != 0);
            repeat (burst) begin
               send_request(imm_pkg::OP_ACCUMULATE, rand_current(), rand_voltage());
            end
            send_request(imm_pkg::OP_READ, $urandom, 24'($urandom));
            sent += burst + 1;
         end
      end
      request_gaps_on = 1'b1;
      drain_gaps_on   = 1'b1;
   endtask

   initial begin
      start_bound = imm_pkg::DEFAULT_BOUND;
      clear_interval_model();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_interval();
      test_field_extremes();
      test_bound_outside_samples();
      test_bound_register();
      test_output_backpressure();
      test_random_intervals();
      wait_for_idle();
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin : drain_reports
      int unsigned gap;
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_pending = 1'b0;
            rsp_tready <= 1'b1;
         end else begin
            gap = drain_gaps_on ? pick_gap() : 0;
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(negedge clock);
            end
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic compare_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : check_reports
      interval_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_reports.size() == 0) begin
            $error("report arrived with none outstanding");
            mismatch_count++;
         end else begin
            want = expected_reports.pop_front();
            compare_field("mean_current", want.mean_current, $signed(rsp_tdata[31:0]));
            compare_field("mean_voltage", want.mean_voltage, $signed(rsp_tdata[55:32]));
            compare_field("lowest_current", want.lowest_current,
                          $signed(rsp_tdata[87:56]));
            compare_field("highest_current", want.highest_current,
                          $signed(rsp_tdata[119:88]));
            compare_field("interval_samples", want.interval_samples, rsp_tdata[151:120]);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
